// ===== hw/rtl/ctcgd_pkg.sv =====
// ----------------------------------------------------------------------------
// ctcgd_pkg
// Types, widths and register indexes shared by the greedy CTC decoder files.
// ----------------------------------------------------------------------------
package ctcgd_pkg;

    localparam int SCORE_BITS      = 16;
    localparam int TOK_W           = 13;
    localparam int DICT_W          = 14;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 14;
    localparam int MAX_CLASSES_DEF = 8192;
    localparam int MAX_TOKENS_DEF  = 64;

    localparam logic [DICT_W-1:0] DICT_RESET = 14'd8192;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RTL_MODE  = 1'b0,
        CFG_DICT_SIZE = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic signed [SCORE_BITS-1:0] score;
        logic                         step_end;
        logic                         sequence_end;
    } in_item_t;

    typedef struct packed {
        logic [TOK_W-1:0]             token_index;
        logic                         token_valid;
        logic signed [SCORE_BITS-1:0] confidence;
        logic                         overflow;
        logic                         last;
    } out_item_t;

endpackage

// ===== hw/rtl/ctc_greedy_decoder.sv =====
// ----------------------------------------------------------------------------
// ctc_greedy_decoder
// Greedy CTC decoder: per-step argmax, blank and repeat collapse, token
// buffer in RAM, drain with optional reversal and mean-score confidence.
// ----------------------------------------------------------------------------
// Scores are taken one per cycle; each non-final item has no result.
// At sequence end the sum/count divide runs, and is not started when no token is
// kept; each token is then read from RAM and loaded into the output register.
// Input is held off from sequence end until the last result is loaded into
// the output register. Async active-low reset clears all control state and
// sets rtl_mode 0, dictionary_size 8192.
module ctc_greedy_decoder #(
    parameter int MAX_CLASSES = ctcgd_pkg::MAX_CLASSES_DEF,
    parameter int MAX_TOKENS  = ctcgd_pkg::MAX_TOKENS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  ctcgd_pkg::in_item_t                 item,
    output logic                                result_valid,
    input  logic                                result_stall,
    output ctcgd_pkg::out_item_t                result,
    input  logic                                cfg_we,
    input  logic [ctcgd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ctcgd_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int SB    = ctcgd_pkg::SCORE_BITS;
    localparam int CW    = $clog2(MAX_CLASSES);
    localparam int CCW   = $clog2(MAX_CLASSES + 1);
    localparam int CNT_W = $clog2(MAX_TOKENS + 1);
    localparam int AW    = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
    localparam int SUM_W = SB + $clog2(MAX_TOKENS) + 1;
    localparam int DW    = ctcgd_pkg::DICT_W;
    localparam int CMP_W = (CW > DW) ? CW : DW;
    localparam int TW    = ctcgd_pkg::TOK_W;

    typedef enum logic [1:0] {S_ACC, S_DIV, S_RD, S_LOAD} state_t;

    state_t                  state_reg;
    logic                    rtl_mode_reg;
    logic [DW-1:0]           dict_size_reg;

    logic signed [SB-1:0]    best_score_reg;
    logic [CW-1:0]           best_class_reg;
    logic [CCW-1:0]          cls_cnt_reg;
    logic [CW-1:0]           prev_reg;
    logic [CNT_W-1:0]        tok_cnt_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic                    drop_flag_reg;

    logic [CNT_W-1:0]        n_reg;
    logic [CNT_W-1:0]        left_reg;
    logic [AW-1:0]           pos_reg;
    logic                    drop_snap_reg;
    logic signed [SB-1:0]    conf_reg;
    logic                    out_valid_reg;
    ctcgd_pkg::out_item_t    out_reg;

    logic                    in_acc;
    logic                    out_free;
    logic                    in_range;
    logic                    take;
    logic signed [SB-1:0]    cur_score;
    logic [CW-1:0]           cur_class;
    logic                    step_done;
    logic [CW-1:0]           prev_next;
    logic [CNT_W-1:0]        tok_cnt_next;
    logic signed [SUM_W-1:0] sum_next;
    logic                    drop_next;
    logic                    ram_we;
    logic                    ram_re;
    logic [TW-1:0]           ram_rdata;
    logic                    div_start;
    logic                    div_done;
    logic signed [SUM_W-1:0] div_quot;
    logic                    drain_last;

    assign item_stall   = (state_reg != S_ACC);
    assign in_acc       = item_valid && !item_stall;
    assign out_free     = !out_valid_reg || !result_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    assign drain_last   = (left_reg == CNT_W'(1));

    // per-item argmax and step-end collapse
    always_comb
    begin
        in_range  = (cls_cnt_reg < CCW'(MAX_CLASSES));
        take      = in_range && ((cls_cnt_reg == '0) || (item.score > best_score_reg));
        cur_score = take ? item.score : best_score_reg;
        cur_class = take ? CW'(cls_cnt_reg) : best_class_reg;
        step_done = item.step_end || item.sequence_end;

        prev_next    = prev_reg;
        tok_cnt_next = tok_cnt_reg;
        sum_next     = sum_reg;
        drop_next    = drop_flag_reg;
        ram_we       = 1'b0;
        if (step_done)
        begin
            if (cur_class == '0)
            begin
                prev_next = '0;
            end
            else if (cur_class != prev_reg)
            begin
                prev_next = cur_class;
                if (CMP_W'(cur_class) < CMP_W'(dict_size_reg))
                begin
                    if (tok_cnt_reg < CNT_W'(MAX_TOKENS))
                    begin
                        ram_we       = in_acc;
                        tok_cnt_next = tok_cnt_reg + 1'b1;
                        sum_next     = sum_reg + SUM_W'(cur_score);
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                end
            end
        end
    end

    assign div_start = in_acc && item.sequence_end && (tok_cnt_next != '0);
    assign ram_re    = (state_reg == S_RD) && out_free && (n_reg != '0);

    ctcgd_ram #(
        .WIDTH (TW),
        .DEPTH (MAX_TOKENS),
        .AW    (AW)
    ) u_token_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tok_cnt_reg[AW-1:0]),
        .wdata (TW'(cur_class)),
        .re    (ram_re),
        .raddr (pos_reg),
        .rdata (ram_rdata)
    );

    ctcgd_div #(
        .DVD_W (SUM_W),
        .DVS_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (tok_cnt_next),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rtl_mode_reg  <= 1'b0;
            dict_size_reg <= ctcgd_pkg::DICT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ctcgd_pkg::CFG_RTL_MODE:  rtl_mode_reg  <= cfg_data[0];
                ctcgd_pkg::CFG_DICT_SIZE: dict_size_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_ACC;
            best_score_reg <= '0;
            best_class_reg <= '0;
            cls_cnt_reg    <= '0;
            prev_reg       <= '0;
            tok_cnt_reg    <= '0;
            sum_reg        <= '0;
            drop_flag_reg  <= 1'b0;
            n_reg          <= '0;
            left_reg       <= '0;
            pos_reg        <= '0;
            drop_snap_reg  <= 1'b0;
            conf_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
        end
        else
        begin
            if (out_valid_reg && !result_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_ACC:
                begin
                    if (in_acc)
                    begin
                        if (in_range)
                        begin
                            cls_cnt_reg <= cls_cnt_reg + 1'b1;
                        end
                        if (take)
                        begin
                            best_score_reg <= item.score;
                            best_class_reg <= CW'(cls_cnt_reg);
                        end
                        if (step_done)
                        begin
                            cls_cnt_reg   <= '0;
                            prev_reg      <= prev_next;
                            tok_cnt_reg   <= tok_cnt_next;
                            sum_reg       <= sum_next;
                            drop_flag_reg <= drop_next;
                        end
                        if (item.sequence_end)
                        begin
                            // snapshot the sequence, clear for the next one
                            prev_reg      <= '0;
                            tok_cnt_reg   <= '0;
                            sum_reg       <= '0;
                            drop_flag_reg <= 1'b0;
                            n_reg         <= tok_cnt_next;
                            left_reg      <= tok_cnt_next;
                            drop_snap_reg <= drop_next;
                            conf_reg      <= '0;
                            pos_reg       <= rtl_mode_reg ? AW'(tok_cnt_next - 1'b1) : '0;
                            state_reg     <= S_DIV;
                        end
                    end
                end
                S_DIV:
                begin
                    if (n_reg == '0)
                    begin
                        state_reg <= S_RD;
                    end
                    else if (div_done)
                    begin
                        conf_reg  <= div_quot[SB-1:0];
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    if (out_free)
                    begin
                        if (n_reg == '0)
                        begin
                            out_reg.token_index <= '0;
                            out_reg.token_valid <= 1'b0;
                            out_reg.confidence  <= '0;
                            out_reg.overflow    <= drop_snap_reg;
                            out_reg.last        <= 1'b1;
                            out_valid_reg       <= 1'b1;
                            state_reg           <= S_ACC;
                        end
                        else
                        begin
                            state_reg <= S_LOAD;
                        end
                    end
                end
                S_LOAD:
                begin
                    out_reg.token_index <= ram_rdata;
                    out_reg.token_valid <= 1'b1;
                    out_reg.confidence  <= drain_last ? conf_reg : '0;
                    out_reg.overflow    <= drain_last && drop_snap_reg;
                    out_reg.last        <= drain_last;
                    out_valid_reg       <= 1'b1;
                    left_reg            <= left_reg - 1'b1;
                    pos_reg             <= rtl_mode_reg ? pos_reg - 1'b1 : pos_reg + 1'b1;
                    state_reg           <= drain_last ? S_ACC : S_RD;
                end
                default:
                begin
                    state_reg <= S_ACC;
                end
            endcase
        end
    end

    // no token write while a sequence is draining
    a_no_write_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_ACC) |-> !ram_we)
        else $error("token write outside accumulation");

    // read data must land in an empty output register
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) |-> !out_valid_reg)
        else $error("output register busy at read return");

    a_mid_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.last) |->
            (out_reg.token_valid && !out_reg.overflow && out_reg.confidence == '0))
        else $error("non-final result carries summary fields");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tok_cnt_reg <= CNT_W'(MAX_TOKENS))
        else $error("token count past capacity");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divide finished outside divide state");

endmodule

// ===== hw/rtl/ctcgd_ram.sv =====
// ----------------------------------------------------------------------------
// ctcgd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ctcgd_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/ctcgd_div.sv =====
// ----------------------------------------------------------------------------
// ctcgd_div
// Signed by unsigned restoring divider, one quotient bit per cycle,
// truncating toward zero.
// ----------------------------------------------------------------------------
module ctcgd_div #(
    parameter int DVD_W = 23,
    parameter int DVS_W = 7
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0]        divisor,
    output logic                    done,
    output logic signed [DVD_W-1:0] quotient
);

    localparam int ITER_W = $clog2(DVD_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic              neg_reg;
    logic [ITER_W-1:0] iter_reg;
    logic [DVD_W-1:0]  q_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [DVS_W-1:0]  dvs_reg;

    logic [DVD_W-1:0]  mag;
    logic [DVS_W:0]    rem_sh;
    logic              q_bit;
    logic [DVS_W-1:0]  rem_next;

    always_comb
    begin
        mag    = dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
        rem_sh = {rem_reg, q_reg[DVD_W-1]};
        q_bit  = (rem_sh >= {1'b0, dvs_reg});
        if (q_bit)
        begin
            rem_next = DVS_W'(rem_sh - {1'b0, dvs_reg});
        end
        else
        begin
            rem_next = DVS_W'(rem_sh);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            neg_reg  <= 1'b0;
            iter_reg <= '0;
            q_reg    <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                neg_reg  <= dividend[DVD_W-1];
                iter_reg <= ITER_W'(DVD_W);
                q_reg    <= mag;
                rem_reg  <= '0;
                dvs_reg  <= divisor;
            end
            else if (busy_reg)
            begin
                // shift in one dividend bit, keep one quotient bit
                q_reg    <= {q_reg[DVD_W-2:0], q_bit};
                rem_reg  <= rem_next;
                iter_reg <= iter_reg - 1'b1;
                if (iter_reg == ITER_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = $signed(neg_reg ? (~q_reg + 1'b1) : q_reg);

endmodule

// ===== bench/ctc_greedy_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// ctc_greedy_decoder_tb
// Self-checking bench for the greedy CTC decoder. Score items stream in as
// class scores grouped into time steps and sequences. A behavioral decoder
// in the bench predicts the drained tokens, and the bench checks every result
// field. Register settings change between phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctc_greedy_decoder_tb;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASES        = 6;

    typedef struct packed {
        ctcgd_pkg::in_item_t  stim;
        logic                 typed;
        ctcgd_pkg::out_item_t want;
    } probe_row_t;

    localparam ctcgd_pkg::out_item_t NONE_DUE = '0;

    logic                             clk;
    logic                             rst_n        = 1'b0;
    logic                             item_valid   = 1'b0;
    logic                             item_stall;
    ctcgd_pkg::in_item_t              item         = '0;
    logic                             result_valid;
    logic                             result_stall = 1'b0;
    ctcgd_pkg::out_item_t             result;
    logic                             cfg_we       = 1'b0;
    logic [ctcgd_pkg::CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [ctcgd_pkg::CFG_DATA_W-1:0] cfg_data     = '0;

    // Decoder mirror: step argmax, collapse state, token store, registers.
    logic signed [ctcgd_pkg::SCORE_BITS-1:0] step_peak       = '0;
    logic [ctcgd_pkg::TOK_W-1:0]             step_peak_class = '0;
    int                                      step_classes    = 0;
    logic [ctcgd_pkg::TOK_W-1:0]             prior_class     = '0;
    logic [ctcgd_pkg::TOK_W-1:0]             kept_tokens [ctcgd_pkg::MAX_TOKENS_DEF];
    int                                      kept_count      = 0;
    longint                                  kept_sum        = 0;
    logic                                    tokens_lost     = 1'b0;
    logic                                    reverse_order   = 1'b0;
    logic [ctcgd_pkg::DICT_W-1:0]            dict_limit      = ctcgd_pkg::DICT_RESET;

    ctcgd_pkg::out_item_t fresh_tokens [$];
    ctcgd_pkg::out_item_t due_tokens [$];

    int items_sent    = 0;
    int results_seen  = 0;
    int mismatches    = 0;
    int cycle_count   = 0;
    int idle_profile  = 0;
    int hold_request  = 0;
    int hold_left     = 0;

    int tx_idle_pct [3] = '{33, 55, 0};
    int rx_idle_pct [3] = '{55, 33, 0};
    int phase_quota [PHASES] = '{25, 25, 25, 25, 25, 25};
    int phase_rtl   [PHASES] = '{0, 1, 0, 1, 1, 0};
    int phase_dict  [PHASES] = '{8192, 5, 1, 0, 8192, 3};

    // Directed items run right after reset with rtl_mode 0, dictionary 8192.
    probe_row_t directed_rows [17] = '{
        // lone blank step ending the sequence: empty result
        '{'{16'sh0000, 1'b0, 1'b1}, 1'b1, '{13'd0, 1'b0, 16'sh0000, 1'b0, 1'b1}},
        // most negative scores: class 1 wins by one LSB
        '{'{16'sh8000, 1'b0, 1'b0}, 1'b0, NONE_DUE},
        '{'{16'sh8001, 1'b0, 1'b1}, 1'b1, '{13'd1, 1'b1, 16'sh8001, 1'b0, 1'b1}},
        // class 1 at full scale
        '{'{16'sh0064, 1'b0, 1'b0}, 1'b0, NONE_DUE},
        '{'{16'sh7FFF, 1'b0, 1'b0}, 1'b0, NONE_DUE},
        '{'{16'sh0005, 1'b1, 1'b0}, 1'b0, NONE_DUE},
        // repeat of class 1 with a later tie: collapsed
        '{'{16'shFFFF, 1'b0, 1'b0}, 1'b0, NONE_DUE},
        '{'{16'sh7FFF, 1'b0, 1'b0}, 1'b0, NONE_DUE},
        '{'{16'sh7FFF, 1'b1, 1'b0}, 1'b0, NONE_DUE},
        // one-class step: blank clears the previous class
        '{'{16'sh0007, 1'b1, 1'b0}, 1'b0, NONE_DUE},
        // tie with class 0: blank again
        '{'{16'shFFFB, 1'b0, 1'b0}, 1'b0, NONE_DUE},
        '{'{16'shFFFB, 1'b1, 1'b0}, 1'b0, NONE_DUE},
        // class 1 kept once more, sequence end without step end
        '{'{16'shFF9C, 1'b0, 1'b0}, 1'b0, NONE_DUE},
        '{'{16'sh7FFF, 1'b0, 1'b1}, 1'b0, NONE_DUE},
        // both end flags on class 2
        '{'{16'sh0000, 1'b0, 1'b0}, 1'b0, NONE_DUE},
        '{'{16'sh8000, 1'b0, 1'b0}, 1'b0, NONE_DUE},
        '{'{16'sh7FFF, 1'b1, 1'b1}, 1'b1, '{13'd2, 1'b1, 16'sh7FFF, 1'b0, 1'b1}}
    };

    ctc_greedy_decoder uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic void decode_score(ctcgd_pkg::in_item_t it);
        logic [ctcgd_pkg::TOK_W-1:0] c;
        longint                      mean;
        ctcgd_pkg::out_item_t        o;
        int                          pos;
        fresh_tokens.delete();
        if (step_classes < ctcgd_pkg::MAX_CLASSES_DEF)
        begin
            if (step_classes == 0 || $signed(it.score) > step_peak)
            begin
                step_peak       = it.score;
                step_peak_class = step_classes[ctcgd_pkg::TOK_W-1:0];
            end
            step_classes++;
        end
        if (!it.step_end && !it.sequence_end)
            return;
        step_classes = 0;
        c = step_peak_class;
        if (c == '0)
            prior_class = '0;
        else if (c != prior_class)
        begin
            prior_class = c;
            if ({1'b0, c} < dict_limit)
            begin
                if (kept_count < ctcgd_pkg::MAX_TOKENS_DEF)
                begin
                    kept_tokens[kept_count] = c;
                    kept_count++;
                    kept_sum += step_peak;
                end
                else
                    tokens_lost = 1'b1;
            end
        end
        if (!it.sequence_end)
            return;
        mean = (kept_count > 0) ? kept_sum / kept_count : 0;
        if (kept_count == 0)
        begin
            o            = '0;
            o.overflow   = tokens_lost;
            o.last       = 1'b1;
            fresh_tokens = {fresh_tokens, o};
        end
        else
        begin
            for (int k = 0; k < kept_count; k++)
            begin
                pos           = reverse_order ? kept_count - 1 - k : k;
                o.token_index = kept_tokens[pos];
                o.token_valid = 1'b1;
                o.last        = (k == kept_count - 1);
                o.confidence  = o.last ? mean[ctcgd_pkg::SCORE_BITS-1:0] : '0;
                o.overflow    = o.last ? tokens_lost : 1'b0;
                fresh_tokens  = {fresh_tokens, o};
            end
        end
        prior_class  = '0;
        kept_count   = 0;
        kept_sum     = 0;
        tokens_lost  = 1'b0;
        step_classes = 0;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        if (mismatches < 200)
            $display("mismatch at result %0d: %s got %0d expected %0d",
                     results_seen, what, got, want);
        mismatches++;
    endtask

    // Offer one item, hold it until taken, then log its expected tokens.
    task automatic push_item(ctcgd_pkg::in_item_t it, logic typed,
                             ctcgd_pkg::out_item_t want);
        @(negedge clk);
        while ($urandom_range(0, 99) < tx_idle_pct[idle_profile])
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (item_stall !== 1'b0);
        items_sent++;
        decode_score(it);
        if (typed)
            due_tokens = {due_tokens, want};
        else
            due_tokens = {due_tokens, fresh_tokens};
    endtask

    // One time step of class scores; the target class carries the peak unless the step is drawn as noise.
    task automatic send_step(int width, int target, logic closes, logic allow_noise);
        int                  peak;
        int                  sc;
        logic                noisy;
        ctcgd_pkg::in_item_t it;
        peak  = int'($urandom_range(0, 65533)) - 32767;
        noisy = allow_noise && (width <= 64) && ($urandom_range(0, 7) == 0);
        for (int k = 0; k < width; k++)
        begin
            if (k >= ctcgd_pkg::MAX_CLASSES_DEF)
                sc = 32767;  // past the last class: must be ignored
            else if (noisy)
                sc = int'($urandom_range(0, 65535)) - 32768;
            else if (k == target)
                sc = peak;
            else if (k < target)
                sc = peak - int'($urandom_range(1, peak + 32768));
            else
                sc = peak - int'($urandom_range(0, peak + 32768));
            it.score        = sc[ctcgd_pkg::SCORE_BITS-1:0];
            it.step_end     = (k == width - 1) ? (closes ? 1'($urandom_range(0, 1)) : 1'b1)
                                               : 1'b0;
            it.sequence_end = closes && (k == width - 1);
            push_item(it, 1'b0, NONE_DUE);
        end
    endtask

    // Chained sequences alternate classes 1 and 2 so no step collapses as a blank or a repeat.
    task automatic send_sequence(int n_steps, logic chain);
        int w;
        int t;
        for (int s = 0; s < n_steps; s++)
        begin
            if (chain)
                send_step(3, 1 + s % 2, s == n_steps - 1, 1'b0);
            else
            begin
                w = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
                t = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, w - 1);
                send_step(w, t, s == n_steps - 1, 1'b1);
            end
        end
    endtask

    // Drop valid, drain every due token, let the divider settle.
    task automatic settle_block();
        @(negedge clk);
        item_valid <= 1'b0;
        while (due_tokens.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_register(ctcgd_pkg::cfg_index_t idx, int value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[ctcgd_pkg::CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            ctcgd_pkg::CFG_RTL_MODE:  reverse_order = value[0];
            ctcgd_pkg::CFG_DICT_SIZE: dict_limit    = value[ctcgd_pkg::DICT_W-1:0];
            default: ;
        endcase
    endtask

    // Receiver: random stalls per profile, or a long hold when requested.
    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else
            result_stall <= ($urandom_range(0, 99) < rx_idle_pct[idle_profile]);
    end

    always @(posedge clk)
    begin : check_results
        ctcgd_pkg::out_item_t want;
        if (rst_n && result_valid === 1'b1 && result_stall === 1'b0)
        begin
            results_seen++;
            if (due_tokens.size() == 0)
                report_mismatch("unexpected result, token_index", result.token_index, 0);
            else
            begin
                want = due_tokens.pop_front();
                if (result.token_index !== want.token_index)
                    report_mismatch("token_index", result.token_index, want.token_index);
                if (result.token_valid !== want.token_valid)
                    report_mismatch("token_valid", result.token_valid, want.token_valid);
                if (result.confidence !== want.confidence)
                    report_mismatch("confidence", $signed(result.confidence),
                                    $signed(want.confidence));
                if (result.overflow !== want.overflow)
                    report_mismatch("overflow", result.overflow, want.overflow);
                if (result.last !== want.last)
                    report_mismatch("last", result.last, want.last);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_count, due_tokens.size());
            $display("ctc_greedy_decoder_tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        int start;
        int n;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph > 0)
            begin
                settle_block();
                set_register(ctcgd_pkg::CFG_RTL_MODE, phase_rtl[ph]);
                set_register(ctcgd_pkg::CFG_DICT_SIZE, phase_dict[ph]);
            end
            idle_profile = ph / 2;
            if (ph == 0)
                foreach (directed_rows[r])
                    push_item(directed_rows[r].stim, directed_rows[r].typed,
                              directed_rows[r].want);
            // Long receiver hold while items keep coming: back up the block.
            if (ph == 1)
                hold_request = 300;
            start = items_sent;
            while (items_sent - start < phase_quota[ph])
            begin
                n = $urandom_range(1, 6);
                send_sequence(n, 1'b0);
            end
            // Overrun the token store.
            if (ph == 1)
                send_sequence(66, 1'b1);
        end
        settle_block();
        if (mismatches == 0)
            $display("ctc_greedy_decoder_tb: PASS");
        else
            $display("ctc_greedy_decoder_tb: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/ctcgd_pkg.sv
hw/rtl/ctcgd_ram.sv
hw/rtl/ctcgd_div.sv
hw/rtl/ctc_greedy_decoder.sv
bench/ctc_greedy_decoder_tb.sv
